@@ hw/rtl/mts_pkg.sv @@
// mts_pkg: shared types and constants for the minimum-tracking stack.
// No dependencies; used by mts_cell, mts_chain and min_tracking_stack_core.
`default_nettype none

package mts_pkg;

  localparam int unsigned StackDepthDef = 64;
  localparam int unsigned ValueWidthDef = 32;

  localparam int unsigned FuncWidth  = 2;
  localparam int unsigned FaultWidth = 2;

  typedef enum logic [FuncWidth-1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_PEEK = 2'd2,
    FUNC_RSVD = 2'd3
  } func_e;

  typedef enum logic [FaultWidth-1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_FULL  = 2'd1,
    FAULT_EMPTY = 2'd2,
    FAULT_RSVD  = 2'd3
  } fault_e;

  // Shift control shared by every cell of one chain.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/mts_cell.sv @@
// mts_cell: one entry of a shifting stack chain.
// Depends on mts_pkg (shift_ctl_t).
`default_nettype none

module mts_cell #(
  parameter int unsigned VALUE_WIDTH = mts_pkg::ValueWidthDef
) (
  input  wire logic                   clk_i,
  input  wire mts_pkg::shift_ctl_t    ctl_i,
  input  wire logic [VALUE_WIDTH-1:0] above_i,
  input  wire logic [VALUE_WIDTH-1:0] below_i,
  output logic      [VALUE_WIDTH-1:0] data_o
);

  logic [VALUE_WIDTH-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    if (ctl_i.push) begin
      data_d = above_i;
    end else if (ctl_i.pop) begin
      data_d = below_i;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

@@ hw/rtl/mts_chain.sv @@
// mts_chain: row of mts_cell entries forming a LIFO; entry 0 is the top.
// Depends on mts_pkg and mts_cell.
`default_nettype none

module mts_chain #(
  parameter int unsigned STACK_DEPTH = mts_pkg::StackDepthDef,
  parameter int unsigned VALUE_WIDTH = mts_pkg::ValueWidthDef
) (
  input  wire logic                   clk_i,
  input  wire mts_pkg::shift_ctl_t    ctl_i,
  input  wire logic [VALUE_WIDTH-1:0] push_data_i,
  output logic      [VALUE_WIDTH-1:0] top_o,
  output logic      [VALUE_WIDTH-1:0] second_o
);

  logic [VALUE_WIDTH-1:0] data [STACK_DEPTH];

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    logic [VALUE_WIDTH-1:0] above, below;
    if (g == 0) begin : g_first
      assign above = push_data_i;
    end else begin : g_mid
      assign above = data[g-1];
    end
    if (g == STACK_DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner
      assign below = data[g+1];
    end

    mts_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl_i),
      .above_i(above),
      .below_i(below),
      .data_o (data[g])
    );
  end

  assign top_o    = data[0];
  assign second_o = data[1];

endmodule

`default_nettype wire

@@ hw/rtl/min_tracking_stack_core.sv @@
// min_tracking_stack_core: stack of signed values with a running-minimum stack.
// Depends on mts_pkg and mts_chain (two chains of mts_cell).
//
//  channel  dir  tdata fields (lowest bit first)                     tuser/tlast
//  s_axis   in   func, push_value                                    none
//  m_axis   out  top_value, min_value, fill_count, is_empty, fault   none
//
// One transaction per cycle unless stalled: both stacks are shifting cell chains,
// so a push or pop only moves every cell by one place and the tops are always
// registered. A result sits in the output register from the cycle after its input
// is taken; s_axis_tready drops only while that register is full and stalled.
// Reset clears both fill counts and the output valid; cell contents stay unset.
`default_nettype none

module min_tracking_stack_core #(
  parameter int unsigned STACK_DEPTH = mts_pkg::StackDepthDef,
  parameter int unsigned VALUE_WIDTH = mts_pkg::ValueWidthDef,
  localparam int unsigned CntW    = $clog2(STACK_DEPTH + 1),
  localparam int unsigned InBits  = mts_pkg::FuncWidth + VALUE_WIDTH,
  localparam int unsigned InW     = ((InBits + 7) / 8) * 8,
  localparam int unsigned OutBits = 2 * VALUE_WIDTH + CntW + 1 + mts_pkg::FaultWidth,
  localparam int unsigned OutW    = ((OutBits + 7) / 8) * 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic [InW-1:0]  s_axis_tdata,  // func, push_value
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic      [OutW-1:0] m_axis_tdata   // top_value, min_value, fill_count,
                                              // is_empty, fault
);

  localparam logic [CntW-1:0] CntFull = CntW'(STACK_DEPTH);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  mts_pkg::func_e         func;
  logic [VALUE_WIDTH-1:0] push_value;
  logic                   accept;

  logic [CntW-1:0] vcnt_d, vcnt_q, mcnt_d, mcnt_q;
  mts_pkg::shift_ctl_t    val_ctl, min_ctl;
  logic [VALUE_WIDTH-1:0] val_top, val_second, min_top, min_second;
  logic                   take_min;

  logic [VALUE_WIDTH-1:0] top_d, min_d;
  mts_pkg::fault_e        fault_d;
  logic                   out_valid_q;
  logic [OutBits-1:0]     out_d, out_q;

  assign func       = mts_pkg::func_e'(s_axis_tdata[mts_pkg::FuncWidth-1:0]);
  assign push_value = s_axis_tdata[mts_pkg::FuncWidth +: VALUE_WIDTH];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign take_min = (mcnt_q == '0) || ($signed(push_value) <= $signed(min_top));

  always_comb begin
    val_ctl = '0;
    min_ctl = '0;
    vcnt_d  = vcnt_q;
    mcnt_d  = mcnt_q;
    fault_d = mts_pkg::FAULT_NONE;
    top_d   = val_top;
    min_d   = min_top;
    unique case (func)
      mts_pkg::FUNC_PUSH: begin
        if (vcnt_q == CntFull) begin
          fault_d = mts_pkg::FAULT_FULL;
        end else begin
          val_ctl.push = accept;
          vcnt_d       = vcnt_q + CntOne;
          top_d        = push_value;
          if (take_min) begin
            min_ctl.push = accept;
            mcnt_d       = mcnt_q + CntOne;
            min_d        = push_value;
          end
        end
      end
      mts_pkg::FUNC_POP: begin
        if (vcnt_q == '0) begin
          fault_d = mts_pkg::FAULT_EMPTY;
        end else begin
          val_ctl.pop = accept;
          vcnt_d      = vcnt_q - CntOne;
          top_d       = val_second;
          if (mcnt_q != '0 && val_top == min_top) begin
            min_ctl.pop = accept;
            mcnt_d      = mcnt_q - CntOne;
            min_d       = min_second;
          end
        end
      end
      default: begin
        // peek, and the unused code behaves the same
      end
    endcase
    if (vcnt_d == '0) begin
      top_d = '0;
      min_d = '0;
    end
    out_d = {fault_d, (vcnt_d == '0), vcnt_d, min_d, top_d};
  end

  mts_chain #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_val_chain (
    .clk_i      (clk_i),
    .ctl_i      (val_ctl),
    .push_data_i(push_value),
    .top_o      (val_top),
    .second_o   (val_second)
  );

  mts_chain #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_min_chain (
    .clk_i      (clk_i),
    .ctl_i      (min_ctl),
    .push_data_i(push_value),
    .top_o      (min_top),
    .second_o   (min_second)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q      <= '0;
      mcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        vcnt_q <= vcnt_d;
        mcnt_q <= mcnt_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'(out_q);

endmodule

`default_nettype wire

@@ test/tb.sv @@
// tb: self-checking testbench for min_tracking_stack_core (push, pop, peek, overflow and
// underflow faults). Depends on mts_pkg and the core RTL; holds its own stack predictor.
`default_nettype none

module tb;
  import mts_pkg::*;

  localparam int unsigned Depth = StackDepthDef;

  typedef struct {
    func_e             func;
    logic signed [31:0] value;
  } stack_op_t;

  typedef struct {
    logic signed [31:0] top;
    logic signed [31:0] least;
    logic [6:0]         fill;
    logic               empty;
    fault_e             fault;
  } stack_status_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // func, push_value
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;       // top_value, min_value, fill_count, is_empty, fault

  min_tracking_stack_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic signed [31:0] value_stk [Depth];
  logic signed [31:0] least_stk [Depth];
  int                 value_n = 0;
  int                 least_n = 0;

  stack_op_t     op_q [$];
  stack_status_t status_q [$];
  stack_op_t     cur_op;
  int            queued_n = 0;
  int            taken_n = 0;
  int            errors = 0;
  logic          calm;

  // no idling on either side for a stretch in the middle of the run
  assign calm = (taken_n >= 300) && (taken_n < 420);

  function automatic stack_status_t apply_op(stack_op_t op);
    stack_status_t r;
    logic          take;
    r.fault = FAULT_NONE;
    case (op.func)
      FUNC_PUSH: begin
        if (value_n >= Depth) begin
          r.fault = FAULT_FULL;
        end else begin
          take = (least_n == 0) || (op.value <= least_stk[least_n-1]);
          value_stk[value_n] = op.value;
          value_n++;
          if (take && least_n < Depth) begin
            least_stk[least_n] = op.value;
            least_n++;
          end
        end
      end
      FUNC_POP: begin
        if (value_n == 0) begin
          r.fault = FAULT_EMPTY;
        end else begin
          if (least_n > 0 && value_stk[value_n-1] == least_stk[least_n-1]) least_n--;
          value_n--;
        end
      end
      default: ;  // peek and the spare code change nothing
    endcase
    r.fill  = value_n[6:0];
    r.empty = (value_n == 0);
    r.top   = (value_n == 0) ? '0 : value_stk[value_n-1];
    r.least = (value_n == 0 || least_n == 0) ? '0 : least_stk[least_n-1];
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        status_q.push_back(apply_op(cur_op));
        taken_n <= taken_n + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (op_q.size() != 0 && (calm || $urandom_range(99) >= 18)) begin
          cur_op = op_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'b0, cur_op.value, cur_op.func};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    stack_status_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (status_q.size() == 0) begin
          $display("%0t: unexpected transaction: expected none, actual %h",
                   $time, m_axis_tdata);
          errors++;
        end else begin
          want = status_q.pop_front();
          check_field("top_value", want.top, m_axis_tdata[31:0]);
          check_field("min_value", want.least, m_axis_tdata[63:32]);
          check_field("fill_count", 32'(want.fill), 32'(m_axis_tdata[70:64]));
          check_field("is_empty", 32'(want.empty), 32'(m_axis_tdata[71]));
          check_field("fault", 32'(want.fault), 32'(m_axis_tdata[73:72]));
        end
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 18);
    end
  end

  task automatic add_op(func_e f, logic signed [31:0] v);
    stack_op_t op;
    op.func  = f;
    op.value = v;
    op_q.push_back(op);
    queued_n++;
  endtask

  function automatic logic signed [31:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) return $signed($urandom_range(15)) - 8;  // narrow range, many ties
    if (sel < 55) begin
      case ($urandom_range(4))
        0: return 32'sh7fffffff;
        1: return 32'sh80000000;
        2: return 32'sh0;
        3: return -32'sh1;
        default: return 32'sh1;
      endcase
    end
    return $signed($urandom());
  endfunction

  function automatic func_e pick_func(int unsigned push_pct, int unsigned pop_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < push_pct) return FUNC_PUSH;
    if (r < push_pct + pop_pct) return FUNC_POP;
    return $urandom_range(1) ? FUNC_PEEK : FUNC_RSVD;
  endfunction

  initial begin
    int unsigned mode;
    int unsigned len;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: empty-stack cases, extremes, ties on the minimum, unwinding
    add_op(FUNC_PEEK, 32'sh0);
    add_op(FUNC_POP, 32'sh5a5a5a5a);
    add_op(FUNC_RSVD, -32'sh1);
    add_op(FUNC_PUSH, 32'sh7fffffff);
    add_op(FUNC_PUSH, 32'sh5);
    add_op(FUNC_PUSH, 32'sh5);
    add_op(FUNC_PUSH, 32'sh55555555);
    add_op(FUNC_PUSH, 32'shaaaaaaaa);
    add_op(FUNC_PUSH, 32'sh80000000);
    add_op(FUNC_PEEK, 32'sh12345678);
    add_op(FUNC_RSVD, 32'sh0);
    add_op(FUNC_POP, 32'sh0);
    add_op(FUNC_POP, 32'sh0);
    add_op(FUNC_POP, 32'sh0);
    add_op(FUNC_POP, 32'sh0);
    add_op(FUNC_POP, 32'sh0);
    add_op(FUNC_POP, 32'sh0);
    add_op(FUNC_POP, 32'sh0);
    add_op(FUNC_PUSH, -32'sh1);
    add_op(FUNC_PUSH, 32'sh0);
    add_op(FUNC_PUSH, -32'sh1);
    add_op(FUNC_POP, 32'sh7fffffff);
    add_op(FUNC_POP, 32'sh0);
    add_op(FUNC_POP, 32'sh0);

    // hold off until the directed results are all back
    while (taken_n != queued_n || status_q.size() != 0) @(negedge clk_i);

    while (queued_n < 830) begin
      mode = $urandom_range(9);
      if (mode < 2) begin
        // fill past full, then drain past empty
        len = Depth + 2 + $urandom_range(4);
        repeat (len) add_op(FUNC_PUSH, pick_value());
        repeat (len) add_op(FUNC_POP, pick_value());
      end else begin
        len = $urandom_range(20, 90);
        repeat (len) begin
          case (mode % 3)
            0: add_op(pick_func(88, 6), pick_value());
            1: add_op(pick_func(8, 86), pick_value());
            default: add_op(pick_func(45, 40), pick_value());
          endcase
        end
      end
    end

    while (taken_n != queued_n || status_q.size() != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("[min_tracking_stack_core] OK");
    end else begin
      $display("[min_tracking_stack_core] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[min_tracking_stack_core] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
